// File: hdl/rtct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_pkg
// Shared types, constants and control store for the rule tree cell
// transition block.
// ----------------------------------------------------------------------------
package rtct_pkg;

  localparam int unsigned NODE_WORDS = 65536;
  localparam int unsigned LEAF_WORDS = 65536;
  localparam int unsigned NODE_AW    = $clog2(NODE_WORDS);
  localparam int unsigned LEAF_AW    = $clog2(LEAF_WORDS);

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned STATE_W = 8;
  localparam int unsigned NB_NUM  = 9;

  // sum width covers every address and a carry; wrap is by truncation,
  // so table sizes are powers of two
  localparam int unsigned MAX_AW = (NODE_AW > LEAF_AW) ? NODE_AW : LEAF_AW;
  localparam int unsigned SUM_W  = ((MAX_AW > WORD_W) ? MAX_AW : WORD_W) + 1;

  localparam logic [1:0] OP_NODE_WR = 2'd0;
  localparam logic [1:0] OP_LEAF_WR = 2'd1;
  localparam logic [1:0] OP_EVAL    = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_ROOT = 1'b1;

  localparam int unsigned UPC_W = 4;

  localparam logic [UPC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [UPC_W-1:0] STEP_FOUR  = 4'd5;

  typedef enum logic [1:0] {
    SEQ_NEXT     = 2'd0,
    SEQ_DISPATCH = 2'd1,
    SEQ_EMIT     = 2'd2,
    SEQ_JUMP     = 2'd3
  } seq_e;

  typedef enum logic [1:0] {
    MOP_NONE = 2'd0,
    MOP_NODE = 2'd1,
    MOP_LEAF = 2'd2
  } mop_e;

  // neighbour index follows the packing order of the request
  typedef enum logic [3:0] {
    NB_NW = 4'd0,
    NB_N  = 4'd1,
    NB_NE = 4'd2,
    NB_W  = 4'd3,
    NB_C  = 4'd4,
    NB_E  = 4'd5,
    NB_SW = 4'd6,
    NB_S  = 4'd7,
    NB_SE = 4'd8
  } nb_e;

  typedef struct packed {
    seq_e             seq;
    mop_e             mop;
    nb_e              nb;
    logic [UPC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic               node_we;
    logic               node_re;
    logic [NODE_AW-1:0] node_addr;
    logic               leaf_we;
    logic               leaf_re;
    logic [LEAF_AW-1:0] leaf_addr;
    logic [WORD_W-1:0]  wdata;
  } mem_req_t;

  // step 0 waits for a request; eight-neighbour walk runs 1..8, four from 5
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] step);
    ucode_t w;
    w = '{seq: SEQ_JUMP, mop: MOP_NONE, nb: NB_C, target: STEP_IDLE};
    case (step)
      4'd0:    w = '{seq: SEQ_DISPATCH, mop: MOP_NONE, nb: NB_C,  target: STEP_FOUR};
      4'd1:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_NW, target: STEP_IDLE};
      4'd2:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_NE, target: STEP_IDLE};
      4'd3:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_SW, target: STEP_IDLE};
      4'd4:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_SE, target: STEP_IDLE};
      4'd5:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_N,  target: STEP_IDLE};
      4'd6:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_W,  target: STEP_IDLE};
      4'd7:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_E,  target: STEP_IDLE};
      4'd8:    w = '{seq: SEQ_NEXT,     mop: MOP_NODE, nb: NB_S,  target: STEP_IDLE};
      4'd9:    w = '{seq: SEQ_NEXT,     mop: MOP_LEAF, nb: NB_C,  target: STEP_IDLE};
      4'd10:   w = '{seq: SEQ_EMIT,     mop: MOP_NONE, nb: NB_C,  target: STEP_IDLE};
      default: w = '{seq: SEQ_JUMP,     mop: MOP_NONE, nb: NB_C,  target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/rtct_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtct_tables
// Node and leaf tables, one port each, registered read data held between
// reads.
// ----------------------------------------------------------------------------
module rtct_tables
  import rtct_pkg::*;
(
  input  logic                clk_i,
  input  mem_req_t            req_i,
  output logic [WORD_W-1:0]   node_rdata_o,
  output logic [STATE_W-1:0]  leaf_rdata_o
);

  logic [WORD_W-1:0]  node_mem [NODE_WORDS];
  logic [STATE_W-1:0] leaf_mem [LEAF_WORDS];
  logic [WORD_W-1:0]  node_rdata_q;
  logic [STATE_W-1:0] leaf_rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.node_we) begin
      node_mem[req_i.node_addr] <= req_i.wdata;
    end
    if (req_i.node_re) begin
      node_rdata_q <= node_mem[req_i.node_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.leaf_we) begin
      leaf_mem[req_i.leaf_addr] <= req_i.wdata[STATE_W-1:0];
    end
    if (req_i.leaf_re) begin
      leaf_rdata_q <= leaf_mem[req_i.leaf_addr];
    end
  end

  assign node_rdata_o = node_rdata_q;
  assign leaf_rdata_o = leaf_rdata_q;

endmodule

// File: hdl/rule_tree_cell_transition.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rule_tree_cell_transition
// Cell state update from a decision-tree rule held in node and leaf tables,
// walked by a small microcoded sequencer.
//
//   channel  dir  handshake          payload
//   s_axis   in   tvalid/tready      tuser opcode, tdata addr/value/cells
//   m_axis   out  tvalid/tready      tdata next_state
//   apb      in   psel/penable       neighbor_mode @0, root_offset @4
//
// Table writes are done as the request is accepted. An evaluate request
// walks a chain of dependent reads on the single node table port, one read
// a step, then reads the leaf table. Reset returns the sequencer to idle,
// clears the output valid and root_offset and sets neighbor_mode to 1; the
// tables are not cleared. A stalled result holds the sequencer at its emit
// step; no request is taken until the step counter is back at idle.
// ----------------------------------------------------------------------------
module rule_tree_cell_transition
  import rtct_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,

  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [15:0] table_address, [31:16] write_value, then 8 bits each:
  // north_west, north, north_east, west, centre, east, south_west,
  // south, south_east
  input  logic [103:0]  s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]    s_axis_tuser_i,

  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [7:0] next_state
  output logic [7:0]    m_axis_tdata_o,

  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic                mode_q;
  logic [WORD_W-1:0]   root_q;
  logic [UPC_W-1:0]    upc_q, upc_d;
  logic                first_q, first_d;
  logic                out_valid_q, out_valid_d;
  logic [STATE_W-1:0]  out_data_q, out_data_d;
  logic [STATE_W-1:0]  nb_q [NB_NUM];

  ucode_t              uw;
  mem_req_t            mem_req;
  logic [WORD_W-1:0]   node_rdata;
  logic [STATE_W-1:0]  leaf_rdata;
  logic                in_accept;
  logic                cfg_write;
  logic [STATE_W-1:0]  nb_sel;
  logic [WORD_W-1:0]   base;
  logic [SUM_W-1:0]    walk_sum;
  logic [SUM_W-1:0]    wr_addr;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      root_q <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_MODE: mode_q <= pwdata[0];
        REG_ROOT: root_q <= pwdata[WORD_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE: prdata = {31'd0, mode_q};
      REG_ROOT: prdata = {16'd0, root_q};
      default:  prdata = '0;
    endcase
  end

  // sequencer
  assign uw              = ucode_rom(upc_q);
  assign s_axis_tready_o = (upc_q == STEP_IDLE);
  assign in_accept       = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      for (int i = 0; i < NB_NUM; i++) begin
        nb_q[i] <= s_axis_tdata_i[32 + STATE_W*i +: STATE_W];
      end
    end
  end

  always_comb begin
    unique case (uw.nb)
      NB_NW:   nb_sel = nb_q[0];
      NB_N:    nb_sel = nb_q[1];
      NB_NE:   nb_sel = nb_q[2];
      NB_W:    nb_sel = nb_q[3];
      NB_C:    nb_sel = nb_q[4];
      NB_E:    nb_sel = nb_q[5];
      NB_SW:   nb_sel = nb_q[6];
      NB_S:    nb_sel = nb_q[7];
      NB_SE:   nb_sel = nb_q[8];
      default: nb_sel = nb_q[4];
    endcase
  end

  assign base     = first_q ? root_q : node_rdata;
  assign walk_sum = SUM_W'(base) + SUM_W'(nb_sel);
  assign wr_addr  = SUM_W'(s_axis_tdata_i[15:0]);

  always_comb begin
    mem_req           = '0;
    mem_req.wdata     = s_axis_tdata_i[31:16];
    mem_req.node_addr = walk_sum[NODE_AW-1:0];
    mem_req.leaf_addr = walk_sum[LEAF_AW-1:0];
    if (uw.seq == SEQ_DISPATCH) begin
      mem_req.node_addr = wr_addr[NODE_AW-1:0];
      mem_req.leaf_addr = wr_addr[LEAF_AW-1:0];
      mem_req.node_we   = in_accept & (s_axis_tuser_i == OP_NODE_WR);
      mem_req.leaf_we   = in_accept & (s_axis_tuser_i == OP_LEAF_WR);
    end
    mem_req.node_re = (uw.mop == MOP_NODE);
    mem_req.leaf_re = (uw.mop == MOP_LEAF);
  end

  always_comb begin
    upc_d       = upc_q + 1'b1;
    first_d     = first_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_data_d  = out_data_q;
    if (uw.mop == MOP_NODE) begin
      first_d = 1'b0;
    end
    unique case (uw.seq)
      SEQ_NEXT: ;
      SEQ_DISPATCH: begin
        first_d = 1'b1;
        if (in_accept && (s_axis_tuser_i == OP_EVAL)) begin
          upc_d = mode_q ? (upc_q + 1'b1) : uw.target;
        end else begin
          upc_d = upc_q;
        end
      end
      SEQ_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = leaf_rdata;
          upc_d       = uw.target;
        end else begin
          upc_d = upc_q;
        end
      end
      SEQ_JUMP: upc_d = uw.target;
      default:  upc_d = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= STEP_IDLE;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  rtct_tables u_tables (
    .clk_i        (clk_i),
    .req_i        (mem_req),
    .node_rdata_o (node_rdata),
    .leaf_rdata_o (leaf_rdata)
  );

endmodule

// File: tb/tb_rule_tree_cell_transition.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rule_tree_cell_transition
// Self-checking bench for the rule tree cell transition block. Node and leaf
// tables are filled along each planned walk before the evaluate request is
// sent, so only written entries are ever read. A scoreboard keeps its own
// copy of the tables and registers, predicts next_state for every accepted
// evaluate and checks results in order. Runs directed corners, then random
// phases with differing source and sink throttling and register settings.
// ----------------------------------------------------------------------------
module tb_rule_tree_cell_transition;
  import rtct_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [2:0] ADDR_ROOT = {REG_ROOT, 2'b00};
  localparam int unsigned DRAIN_TAIL = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_REQUESTS = 135;

  // packed in tdata order, lowest field last
  typedef struct packed {
    logic [7:0]  se;
    logic [7:0]  s;
    logic [7:0]  sw;
    logic [7:0]  e;
    logic [7:0]  c;
    logic [7:0]  w;
    logic [7:0]  ne;
    logic [7:0]  n;
    logic [7:0]  nw;
    logic [15:0] value;
    logic [15:0] addr;
  } cell_req_t;

  class cell_scoreboard;
    logic [15:0] node_tab [NODE_WORDS];
    logic [7:0]  leaf_tab [LEAF_WORDS];
    logic        mode;
    logic [15:0] root;
    logic [7:0]  expected_states [$];
    int unsigned mismatches;

    function new();
      mode = 1'b1;
      root = 16'h0000;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [15:0] v);
      if (idx == REG_MODE) begin
        mode = v[0];
      end else begin
        root = v;
      end
    endfunction

    function logic [7:0] walk_tree(cell_req_t r);
      nb_e         order [8];
      logic [7:0]  cells [NB_NUM];
      logic [15:0] cur;
      logic [15:0] a;
      order = '{NB_NW, NB_NE, NB_SW, NB_SE, NB_N, NB_W, NB_E, NB_S};
      cells[NB_NW] = r.nw;
      cells[NB_N]  = r.n;
      cells[NB_NE] = r.ne;
      cells[NB_W]  = r.w;
      cells[NB_C]  = r.c;
      cells[NB_E]  = r.e;
      cells[NB_SW] = r.sw;
      cells[NB_S]  = r.s;
      cells[NB_SE] = r.se;
      cur = root;
      for (int k = (mode ? 0 : 4); k < 8; k++) begin
        a = cur + 16'(cells[order[k]]);
        cur = node_tab[a];
      end
      a = cur + 16'(r.c);
      return leaf_tab[a];
    endfunction

    function void note_request(logic [1:0] op, cell_req_t r);
      case (op)
        OP_NODE_WR: node_tab[r.addr] = r.value;
        OP_LEAF_WR: leaf_tab[r.addr] = r.value[7:0];
        OP_EVAL:    expected_states = {expected_states, walk_tree(r)};
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("MISMATCH %s: got %02h expected %02h", what, got, want);
      mismatches++;
    endtask

    task check_next_state(logic [7:0] got);
      logic [7:0] want;
      if (expected_states.size() == 0) begin
        report_mismatch("unexpected result", got, 8'h00);
      end else begin
        want = expected_states.pop_front();
        if (got !== want) begin
          report_mismatch("next_state", got, want);
        end
      end
    endtask

    function int pending();
      return expected_states.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid_i;
  logic          s_axis_tready_o;
  logic [103:0]  s_axis_tdata_i;
  logic [1:0]    s_axis_tuser_i;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i;
  logic [7:0]    m_axis_tdata_o;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  cell_scoreboard sb = new();

  bit          node_known [NODE_WORDS];
  bit          leaf_known [LEAF_WORDS];
  int unsigned src_idle;
  int unsigned dst_idle;
  int unsigned hold_req;
  int unsigned requests_sent;
  int unsigned stall_cycles;

  rule_tree_cell_transition uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // sink: random throttling, or a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        m_axis_tready_i <= 1'b0;
        hold_req <= hold_req - 1;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= dst_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_next_state(m_axis_tdata_o);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (psel && penable && pready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic cell_req_t rand_req();
    logic [127:0] t;
    t = {$urandom, $urandom, $urandom, $urandom};
    return t[103:0];
  endfunction

  function automatic cell_req_t with_cells(cell_req_t r, logic [7:0] v);
    r.nw = v; r.n = v; r.ne = v; r.w = v; r.c = v;
    r.e = v;  r.sw = v; r.s = v; r.se = v;
    return r;
  endfunction

  // mostly small states so walks share nodes
  function automatic logic [7:0] rand_state();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  function automatic cell_req_t rand_cell();
    cell_req_t r;
    r = rand_req();
    r.nw = rand_state(); r.n = rand_state(); r.ne = rand_state();
    r.w = rand_state();  r.c = rand_state(); r.e = rand_state();
    r.sw = rand_state(); r.s = rand_state(); r.se = rand_state();
    return r;
  endfunction

  function automatic logic [15:0] pick_node_word();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3)) << 8;
      1: return 16'hFFFF - 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_request(input logic [1:0] op, input cell_req_t r);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= r;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, r);
    if (op != OP_UNUSED) begin
      requests_sent++;
    end
    @(negedge clk_i);
  endtask

  // fills every entry the walk will touch, then sends the evaluate;
  // with fixed set, new entries take fill and nothing is overwritten
  task automatic run_eval(input cell_req_t q, input bit fixed, input logic [15:0] fill);
    nb_e         order [8];
    logic [7:0]  cells [NB_NUM];
    logic [15:0] cur;
    logic [15:0] a;
    cell_req_t   w;
    order = '{NB_NW, NB_NE, NB_SW, NB_SE, NB_N, NB_W, NB_E, NB_S};
    cells[NB_NW] = q.nw; cells[NB_N] = q.n;   cells[NB_NE] = q.ne;
    cells[NB_W]  = q.w;  cells[NB_C] = q.c;   cells[NB_E]  = q.e;
    cells[NB_SW] = q.sw; cells[NB_S] = q.s;   cells[NB_SE] = q.se;
    cur = sb.root;
    for (int k = (sb.mode ? 0 : 4); k < 8; k++) begin
      a = cur + 16'(cells[order[k]]);
      if (!node_known[a] || (!fixed && $urandom_range(0, 7) == 0)) begin
        w = rand_req();
        w.addr = a;
        w.value = fixed ? fill : pick_node_word();
        node_known[a] = 1'b1;
        send_request(OP_NODE_WR, w);
      end
      cur = sb.node_tab[a];
    end
    a = cur + 16'(q.c);
    if (!leaf_known[a] || (!fixed && $urandom_range(0, 7) == 0)) begin
      w = rand_req();
      w.addr = a;
      w.value = fixed ? fill : 16'($urandom);
      leaf_known[a] = 1'b1;
      send_request(OP_LEAF_WR, w);
    end
    send_request(OP_EVAL, q);
  endtask

  task automatic wait_until_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_TAIL) @(negedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == REG_MODE) ? ADDR_MODE : ADDR_ROOT;
    pwdata  <= (idx == REG_MODE) ? {31'd0, v[0]} : {16'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_register(idx, v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    cell_req_t   q;
    cell_req_t   last_cell;
    int unsigned stop_at;
    int unsigned sel;
    bit          hold_done;

    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_NODE_WR;
    m_axis_tready_i <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    src_idle        <= 14;
    dst_idle        <= 46;
    hold_req        <= 0;
    requests_sent = 0;
    stall_cycles  = 0;
    hold_done     = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // corners: unused opcode, all-zero and all-ones cells, wrap on both tables
    q = '1;
    send_request(OP_UNUSED, q);
    run_eval(with_cells(rand_req(), 8'h00), 1'b1, 16'h0000);
    run_eval(with_cells(rand_req(), 8'hFF), 1'b1, 16'hFFFF);
    wait_until_drained();
    write_register(REG_MODE, 16'd0);
    run_eval(rand_cell(), 1'b0, 16'h0000);
    run_eval(with_cells(rand_req(), 8'hFF), 1'b1, 16'hFFFF);
    wait_until_drained();
    write_register(REG_ROOT, 16'hFFFF);
    run_eval(with_cells(rand_req(), 8'h00), 1'b1, 16'h0000);
    run_eval(rand_cell(), 1'b0, 16'h0000);
    wait_until_drained();
    write_register(REG_MODE, 16'd1);
    write_register(REG_ROOT, 16'h0000);
    run_eval(rand_cell(), 1'b0, 16'h0000);

    last_cell = rand_cell();
    for (int ph = 0; ph < 3; ph++) begin
      wait_until_drained();
      src_idle <= (ph == 0) ? 14 : (ph == 1) ? 46 : 0;
      dst_idle <= (ph == 0) ? 46 : (ph == 1) ? 14 : 0;
      write_register(REG_MODE, (ph == 1) ? 16'd0 : 16'd1);
      write_register(REG_ROOT, 16'($urandom));
      stop_at = requests_sent + PHASE_REQUESTS;
      while (requests_sent < stop_at) begin
        if (ph == 0 && !hold_done && hold_req == 0 && requests_sent >= stop_at - 110) begin
          hold_req <= 300;
          hold_done = 1'b1;
        end
        if (requests_sent >= stop_at - PHASE_REQUESTS / 2 &&
            requests_sent < stop_at - PHASE_REQUESTS / 2 + 3) begin
          wait_until_drained();
          write_register(REG_ROOT, 16'($urandom));
        end
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
          last_cell = rand_cell();
          run_eval(last_cell, 1'b0, 16'h0000);
        end else if (sel < 75) begin
          run_eval(last_cell, 1'b0, 16'h0000);
        end else if (sel < 88) begin
          q = rand_req();
          if ($urandom_range(0, 1) == 1) begin
            node_known[q.addr] = 1'b1;
            send_request(OP_NODE_WR, q);
          end else begin
            leaf_known[q.addr] = 1'b1;
            send_request(OP_LEAF_WR, q);
          end
        end else if (sel < 95) begin
          send_request(OP_UNUSED, rand_req());
        end else begin
          wait_until_drained();
        end
      end
    end

    wait_until_drained();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
